// ----- sv/glob_wildcard_match_macros.svh -----
// Assertion macros used by the glob wildcard matcher top level.
`ifndef GLOB_WILDCARD_MATCH_MACROS_SVH
`define GLOB_WILDCARD_MATCH_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GWM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gwm assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GWM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gwm assertion failed");

`else

`define GWM_ASSERT_IMP(lbl, ante, cons)
`define GWM_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- sv/gwm_pkg.sv -----
// Types and constants of the glob wildcard matcher.
`timescale 1ns / 1ps
package gwm_pkg;

  localparam int MaskLenDef = 32;

  localparam logic [7:0] STAR_CH = 8'h2A;
  localparam logic [7:0] ANY_CH  = 8'h3F;
  localparam logic [7:0] NUL_CH  = 8'h00;

  localparam logic [1:0] MODE_MASK   = 2'd0;
  localparam logic [1:0] MODE_TEXT   = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic error;
  } out_item_t;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic       advance;
    logic       append;
    logic       clear;
    logic [7:0] ch;
  } cell_ctl_t;

endpackage

// ----- sv/glob_wildcard_match.sv -----
// Top level of the glob wildcard matcher: control, cell row and result register.
`timescale 1ns / 1ps
// Glob matcher. Feed mask bytes (mode 0), then text bytes (mode 1), then one
// finish item (mode 2); the finish item yields one result {matched, error} and
// returns the block to its reset state. '*' matches any run, '?' any single
// byte, a zero byte ends the mask or the text. The mask lives in a row of
// MASK_LEN cells, one per position, each holding its byte and an active bit;
// the active set is kept closed over stars at all times. A text byte updates
// all cells at once, with the star closure rippling left to right through the
// row, so the row length sets the critical path. The result appears in an
// output register in the cycle after the finish item; mask and text items keep
// flowing while a result waits, and only a finish item is held off while the
// previous result is still stalled. No clearing pass is needed after reset:
// unwritten mask cells are never looked at.
module glob_wildcard_match import gwm_pkg::*; #(
  parameter int MASK_LEN = MaskLenDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

`include "glob_wildcard_match_macros.svh"

  localparam int LenW = $clog2(MASK_LEN + 1);
  localparam logic [LenW-1:0] LenFull = LenW'(MASK_LEN);

  logic [LenW-1:0] len_q, len_d;
  logic mask_closed_q, mask_closed_d;
  logic text_begun_q, text_begun_d;
  logic text_closed_q, text_closed_d;
  logic fault_q, fault_d;
  logic tail_q, tail_d;
  logic out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  logic accept, is_mask, is_text, is_finish, ch_zero;
  logic mask_open, append_en, overflow, advance_en;
  cell_ctl_t ctl;

  logic [MASK_LEN:0]   fwd, carry;
  logic [MASK_LEN:0]   act_vec;

  // Hold off a finish only while the last result is still stuck.
  assign in_stall_o = out_valid_q & out_stall_i & (in_item_i.mode == MODE_FINISH);
  assign accept     = in_valid_i & ~in_stall_o;

  assign is_mask   = accept & (in_item_i.mode == MODE_MASK);
  assign is_text   = accept & (in_item_i.mode == MODE_TEXT);
  assign is_finish = accept & (in_item_i.mode == MODE_FINISH);
  assign ch_zero   = in_item_i.ch == NUL_CH;

  assign mask_open  = is_mask & ~text_begun_q & ~mask_closed_q & ~ch_zero;
  assign append_en  = mask_open & (len_q != LenFull);
  assign overflow   = mask_open & (len_q == LenFull);
  assign advance_en = is_text & ~text_closed_q & ~ch_zero;

  assign ctl.advance = advance_en;
  assign ctl.append  = append_en;
  assign ctl.clear   = is_finish;
  assign ctl.ch      = in_item_i.ch;

  // Row of cells; token and star-closure carry run left to right.
  assign fwd[0]   = 1'b0;
  assign carry[0] = 1'b0;

  for (genvar i = 0; i < MASK_LEN; i++) begin : g_cell
    gwm_cell #(
      .LenW (LenW),
      .Idx  (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .len_i   (len_q),
      .fwd_i   (fwd[i]),
      .carry_i (carry[i]),
      .fwd_o   (fwd[i+1]),
      .carry_o (carry[i+1]),
      .act_o   (act_vec[i])
    );
  end

  // Position past the last cell: reached only, never a mask byte itself.
  always_comb begin
    tail_d = tail_q;
    if (is_finish) begin
      tail_d = 1'b0;
    end else if (advance_en) begin
      tail_d = fwd[MASK_LEN] | carry[MASK_LEN];
    end else if (append_en) begin
      tail_d = tail_q | carry[MASK_LEN];
    end
  end
  assign act_vec[MASK_LEN] = tail_q;

  always_comb begin
    len_d         = len_q;
    mask_closed_d = mask_closed_q;
    text_begun_d  = text_begun_q;
    text_closed_d = text_closed_q;
    fault_d       = fault_q;
    if (is_finish) begin
      len_d         = '0;
      mask_closed_d = 1'b0;
      text_begun_d  = 1'b0;
      text_closed_d = 1'b0;
      fault_d       = 1'b0;
    end else if (is_mask) begin
      if (text_begun_q || overflow) begin
        fault_d = 1'b1;
      end else if (!mask_closed_q && ch_zero) begin
        mask_closed_d = 1'b1;
      end
      if (append_en) begin
        len_d = len_q + LenW'(1);
      end
    end else if (is_text) begin
      text_begun_d  = 1'b1;
      mask_closed_d = 1'b1;
      if (!text_closed_q && ch_zero) begin
        text_closed_d = 1'b1;
      end
    end
  end

  // Result register: load on finish, drop once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (is_finish) begin
      out_valid_d        = 1'b1;
      out_item_d.matched = act_vec[len_q] & ~fault_q;
      out_item_d.error   = fault_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q         <= '0;
      mask_closed_q <= 1'b0;
      text_begun_q  <= 1'b0;
      text_closed_q <= 1'b0;
      fault_q       <= 1'b0;
      tail_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      len_q         <= len_d;
      mask_closed_q <= mask_closed_d;
      text_begun_q  <= text_begun_d;
      text_closed_q <= text_closed_d;
      fault_q       <= fault_d;
      tail_q        <= tail_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `GWM_ASSERT_IMP(a_err_kills_match, out_valid_q && out_item_q.error, !out_item_q.matched)
  `GWM_ASSERT_NXT(a_finish_resets, is_finish, out_valid_q && len_q == '0 && act_vec[0] && !fault_q)
  `GWM_ASSERT_IMP(a_len_bound, 1'b1, len_q <= LenFull)
  `GWM_ASSERT_IMP(a_text_closes_mask, text_begun_q, mask_closed_q)

endmodule

// ----- sv/gwm_cell.sv -----
// One mask position: stored mask byte plus its active bit.
`timescale 1ns / 1ps
module gwm_cell import gwm_pkg::*; #(
  parameter int LenW = 6,
  parameter int Idx  = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctl_t       ctl_i,
  input  logic [LenW-1:0] len_i,
  input  logic            fwd_i,
  input  logic            carry_i,
  output logic            fwd_o,
  output logic            carry_o,
  output logic            act_o
);

  logic [7:0] char_q;
  logic       act_q, act_d;
  logic       in_mask, wr_sel, is_star, hit, stay, closed;

  assign in_mask = LenW'(Idx) < len_i;
  assign wr_sel  = LenW'(Idx) == len_i;
  assign is_star = char_q == STAR_CH;
  assign hit     = (char_q == ANY_CH) || (char_q == ctl_i.ch);

  // A star keeps its own position alive; anything else hands the token right.
  assign stay   = act_q & in_mask & is_star;
  assign fwd_o  = act_q & in_mask & ~is_star & hit;
  assign closed = stay | fwd_i | carry_i;

  always_comb begin
    carry_o = 1'b0;
    if (ctl_i.advance) begin
      carry_o = closed & in_mask & is_star;
    end else if (ctl_i.append) begin
      carry_o = act_q & wr_sel & (ctl_i.ch == STAR_CH);
    end
  end

  always_comb begin
    act_d = act_q;
    if (ctl_i.clear) begin
      act_d = (Idx == 0);
    end else if (ctl_i.advance) begin
      act_d = closed;
    end else if (ctl_i.append) begin
      act_d = act_q | carry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= (Idx == 0);
    end else begin
      act_q <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.append && wr_sel) begin
      char_q <= ctl_i.ch;
    end
  end

  assign act_o = act_q;

endmodule

// ----- verif/glob_wildcard_match_test.sv -----
// Self-checking testbench of the glob wildcard matcher with a built-in match predictor.
`timescale 1ns / 1ps

import gwm_pkg::*;

class verdict_scoreboard;
  logic [7:0]           pattern [MaskLenDef];
  int unsigned          pat_len;
  bit [MaskLenDef:0]    live;
  bit                   pat_closed;
  bit                   text_on;
  bit                   text_done;
  bit                   bad;
  out_item_t            verdicts_due[$];
  int                   mismatches;

  function new();
    mismatches = 0;
    clear();
  endfunction

  function void clear();
    pat_len    = 0;
    live       = '0;
    live[0]    = 1'b1;
    pat_closed = 1'b0;
    text_on    = 1'b0;
    text_done  = 1'b0;
    bad        = 1'b0;
  endfunction

  // A star position that is live also makes the next position live.
  function void spread_stars();
    for (int i = 0; i < pat_len; i++) begin
      if (live[i] && pattern[i] == STAR_CH) live[i+1] = 1'b1;
    end
  endfunction

  function void consume_text(logic [7:0] c);
    bit [MaskLenDef:0] nxt;
    spread_stars();
    nxt = '0;
    for (int i = 0; i < pat_len; i++) begin
      if (live[i]) begin
        if (pattern[i] == STAR_CH) nxt[i] = 1'b1;
        else if (pattern[i] == ANY_CH || pattern[i] == c) nxt[i+1] = 1'b1;
      end
    end
    live = nxt;
    spread_stars();
  endfunction

  function void take_item(in_item_t it);
    out_item_t v;
    case (it.mode)
      MODE_MASK: begin
        if (text_on) begin
          bad = 1'b1;
        end else if (!pat_closed) begin
          if (it.ch == NUL_CH) pat_closed = 1'b1;
          else if (pat_len >= MaskLenDef) bad = 1'b1;
          else begin
            pattern[pat_len] = it.ch;
            pat_len++;
          end
        end
      end
      MODE_TEXT: begin
        text_on    = 1'b1;
        pat_closed = 1'b1;
        if (!text_done) begin
          if (it.ch == NUL_CH) text_done = 1'b1;
          else consume_text(it.ch);
        end
      end
      MODE_FINISH: begin
        spread_stars();
        v.matched = !bad && live[pat_len];
        v.error   = bad;
        verdicts_due.push_back(v);
        clear();
      end
      default: ;
    endcase
  endfunction

  function void flaw(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endfunction

  function void check_verdict(out_item_t got);
    out_item_t want;
    if (verdicts_due.size() == 0) begin
      flaw($sformatf("result with none expected: matched=%b error=%b",
                     got.matched, got.error));
      return;
    end
    want = verdicts_due.pop_front();
    if (got.matched !== want.matched)
      flaw($sformatf("matched expected %b actual %b", want.matched, got.matched));
    if (got.error !== want.error)
      flaw($sformatf("error expected %b actual %b", want.error, got.error));
  endfunction

  function int pending();
    return verdicts_due.size();
  endfunction
endclass

module glob_wildcard_match_test;
  // Mode code the block must ignore.
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int ITEM_GOAL = 1450;
  // Long receiver hold-off, placed well inside the random part.
  localparam int HOLD_AT  = 1500;
  localparam int HOLD_LEN = 400;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  verdict_scoreboard sb;
  int                items_sent;
  bit                tx_calm;
  logic [7:0]        mask_q[$];
  logic [7:0]        text_q[$];

  glob_wildcard_match dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Watch both handshakes; values read here are the ones before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.take_item(in_item_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_verdict(out_item_o);
  end

  // Sender gap: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Mask bytes lean on a tiny alphabet plus wildcards so that matches happen.
  function automatic logic [7:0] mask_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 6)  return "a";
    if (r < 9)  return "b";
    if (r < 10) return "c";
    if (r < 14) return STAR_CH;
    if (r < 17) return ANY_CH;
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8)  return "a";
    if (r < 13) return "b";
    if (r < 15) return "c";
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Build a text that fits the mask, then break it now and then.
  function automatic void fit_text();
    int idx;
    foreach (mask_q[i]) begin
      if (mask_q[i] == STAR_CH) repeat ($urandom_range(0, 2)) text_q.push_back(text_char());
      else if (mask_q[i] == ANY_CH) text_q.push_back(text_char());
      else text_q.push_back(mask_q[i]);
    end
    if (text_q.size() > 0 && $urandom_range(0, 3) == 0) begin
      idx = $urandom_range(0, text_q.size() - 1);
      if ($urandom_range(0, 1)) text_q[idx] = text_char();
      else text_q.delete(idx);
    end
  endfunction

  // Offer one item and hold it until the block takes it. Valid stays high
  // into the next item unless a gap is drawn.
  task automatic offer(input logic [1:0] mode, input logic [7:0] ch);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{mode: mode, ch: ch};
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (mode != MODE_SPARE) items_sent++;
  endtask

  task automatic maybe_spare();
    if ($urandom_range(0, 39) == 0) offer(MODE_SPARE, any_byte());
  endtask

  // One mask/text/finish sequence; a few are pure noise or broken on purpose.
  task automatic run_session();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    tx_calm = ($urandom_range(0, 4) == 0);
    mask_q.delete();
    text_q.delete();
    if (kind >= 95) begin
      // noise: any mode, any byte
      repeat ($urandom_range(1, 6)) offer(2'($urandom_range(0, 3)), any_byte());
      offer(MODE_FINISH, any_byte());
      return;
    end
    if (kind < 10) n = $urandom_range(MaskLenDef - 1, MaskLenDef + 3);
    else if (kind < 15) n = $urandom_range(9, MaskLenDef);
    else n = $urandom_range(0, 8);
    repeat (n) mask_q.push_back(mask_char());
    if ($urandom_range(0, 1)) fit_text();
    else repeat ($urandom_range(0, 10)) text_q.push_back(text_char());

    foreach (mask_q[i]) begin
      maybe_spare();
      offer(MODE_MASK, mask_q[i]);
    end
    if ($urandom_range(0, 1)) begin
      offer(MODE_MASK, NUL_CH);
      // bytes after the mask terminator are dropped
      if ($urandom_range(0, 4) == 0) offer(MODE_MASK, any_byte());
    end
    foreach (text_q[i]) begin
      maybe_spare();
      offer(MODE_TEXT, text_q[i]);
      // mask byte after text has begun
      if (kind >= 88 && i == 0) offer(MODE_MASK, any_byte());
    end
    if ($urandom_range(0, 2) == 0) begin
      offer(MODE_TEXT, NUL_CH);
      repeat ($urandom_range(0, 2)) offer(MODE_TEXT, any_byte());
    end
    offer(MODE_FINISH, any_byte());
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off that
  // backs the block up into its input.
  initial begin : rx_side
    int  cyc;
    int  stall_left;
    int  hold_left;
    int  r;
    bit  calm;
    out_stall_i = 1'b0;
    cyc         = 0;
    stall_left  = 0;
    hold_left   = 0;
    calm        = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 300 == 0) calm = ($urandom_range(0, 2) == 0);
      if (cyc == HOLD_AT) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (!calm) begin
          r = $urandom_range(0, 99);
          if (r < 25) stall_left = $urandom_range(1, 3);
          else if (r < 30) stall_left = $urandom_range(10, 40);
        end
      end
    end
  end

  initial begin : stimulus
    int guard;
    sb         = new();
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    items_sent = 0;
    tx_calm    = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty mask against empty text: a match.
    offer(MODE_FINISH, 8'hFF);
    // Lone star, closed mask, closed empty text; bytes after each terminator drop.
    offer(MODE_MASK, STAR_CH);
    offer(MODE_MASK, NUL_CH);
    offer(MODE_MASK, 8'h41);
    offer(MODE_TEXT, NUL_CH);
    offer(MODE_TEXT, "z");
    offer(MODE_FINISH, NUL_CH);
    // Literal plus any-char, with an unused mode slipped in.
    offer(MODE_MASK, "a");
    offer(MODE_MASK, ANY_CH);
    offer(MODE_SPARE, 8'h5A);
    offer(MODE_TEXT, "a");
    offer(MODE_TEXT, 8'hFF);
    offer(MODE_FINISH, NUL_CH);
    // Mask byte after text has begun: error.
    offer(MODE_MASK, 8'h01);
    offer(MODE_TEXT, 8'h01);
    offer(MODE_MASK, "b");
    offer(MODE_FINISH, 8'h80);
    // Empty mask against non-empty text: no match.
    offer(MODE_TEXT, "x");
    offer(MODE_FINISH, 8'h7F);

    while (items_sent < ITEM_GOAL) run_session();
    in_valid_i <= 1'b0;

    // Drain outstanding results, then let the output settle.
    guard = 0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (sb.pending() != 0 && guard < 20000);
    repeat (8) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+sv
sv/gwm_pkg.sv
sv/gwm_cell.sv
sv/glob_wildcard_match.sv
verif/glob_wildcard_match_test.sv
